### sv/mccm_pkg.sv
// shared types and constants of the convergence monitor
package mccm_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int PASS_BITS   = 20;

   localparam int EL_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
   localparam int CNT_W  = ($clog2(MAX_RESULTS + 1) > 5) ? $clog2(MAX_RESULTS + 1) : 5;
   localparam int EST_W  = 25;
   localparam int SUM_W  = 45;
   localparam int NZ_W   = 20;
   localparam int TOL_W  = 24;
   localparam int CF_W   = 16;
   localparam int ACC_W  = 16;
   localparam int BR_W   = 20;
   localparam int IDX_W  = 4;
   localparam int PCO_W  = 20;
   localparam int DVD_W  = 45;
   localparam int DVS_W  = (PASS_BITS > EST_W) ? PASS_BITS : EST_W;
   localparam int SQ_W   = 49;
   localparam int PROD_W = 2 * EST_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int QDEPTH = 2;

   localparam logic [EST_W-1:0]     ONE_Q24   = EST_W'(25'd16777216);
   localparam logic [SUM_W-1:0]     SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [NZ_W-1:0]      NZ_MAX    = {NZ_W{1'b1}};
   localparam logic [PASS_BITS-1:0] PASS_MAX  = {PASS_BITS{1'b1}};
   localparam logic [TOL_W-1:0]     TOL_MAX   = {TOL_W{1'b1}};
   localparam logic [PASS_BITS-1:0] PASS_TARGET = PASS_BITS'(128);

   localparam logic [CSR_IDX_W-1:0] REG_RESULT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIDENCE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACCURACY     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BAILOUT      = 2'd3;

   localparam logic ACT_CLEAR = 1'b0;
   localparam logic ACT_ADD   = 1'b1;

   typedef struct packed {
      logic             action;
      logic [EST_W-1:0] estimate_value;
   } req_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0] element_index;
      logic [EST_W-1:0] mean_value;
      logic [TOL_W-1:0] relative_tolerance;
      logic             tolerance_valid;
      logic [TOL_W-1:0] worst_tolerance;
      logic [PCO_W-1:0] pass_count;
      logic             pass_done;
      logic             target_met;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQR, ST_ACC, ST_DMEAN, ST_MSQ, ST_DEX2, ST_DVAR,
      ST_SQRT, ST_TMUL, ST_TSTART, ST_DTOL, ST_FIN, ST_EMIT
   } state_type;

endpackage

### sv/mccm_if.sv
// channel interfaces of the convergence monitor
interface mccm_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [24:0] estimate_value;
   modport source (output valid, action, estimate_value, input ready);
   modport sink (input valid, action, estimate_value, output ready);
endinterface

interface mccm_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  element_index;
   logic [24:0] mean_value;
   logic [23:0] relative_tolerance;
   logic        tolerance_valid;
   logic [23:0] worst_tolerance;
   logic [19:0] pass_count;
   logic        pass_done;
   logic        target_met;
   modport source (output valid, element_index, mean_value, relative_tolerance,
                   tolerance_valid, worst_tolerance, pass_count, pass_done,
                   target_met, input ready);
   modport sink (input valid, element_index, mean_value, relative_tolerance,
                 tolerance_valid, worst_tolerance, pass_count, pass_done,
                 target_met, output ready);
endinterface

interface mccm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [19:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/monte_carlo_convergence_monitor_unit.sv
// top level of the monte carlo convergence monitor
//  channel  modport  fields
//  req_if   sink     action, estimate_value
//  rsp_if   source   element_index .. target_met
//  csr_if   sink     index, data (always ready)
// once out of the queue an add item holds the back end for up to four divisions in
// one shared restoring divider plus a 25-step square root; a clear item only
// clears the totals and emits a result
// the two-entry input queue keeps accepting while not full and the back end works
// result register holds until taken; reset is synchronous and clears all totals
module monte_carlo_convergence_monitor_unit (
   input logic          clock,
   input logic          reset,
   mccm_req_if.sink     req_if,
   mccm_rsp_if.source   rsp_if,
   mccm_csr_if.sink     csr_if
);
   import mccm_pkg::*;

   req_type    push_item, pop_item;
   logic       pop_valid, pop;
   csr_wr_type csr_wr;
   rsp_type    out_item;

   assign push_item.action         = req_if.action;
   assign push_item.estimate_value = req_if.estimate_value;
   assign csr_if.ready  = 1'b1;
   assign csr_wr.valid  = csr_if.valid;
   assign csr_wr.index  = csr_if.index;
   assign csr_wr.data   = csr_if.data;

   mccm_queue u_front (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_if.valid),
      .push_ready (req_if.ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   mccm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_pop   (pop),
      .item       (pop_item),
      .csr_wr     (csr_wr),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_item   (out_item)
   );

   assign rsp_if.element_index      = out_item.element_index;
   assign rsp_if.mean_value         = out_item.mean_value;
   assign rsp_if.relative_tolerance = out_item.relative_tolerance;
   assign rsp_if.tolerance_valid    = out_item.tolerance_valid;
   assign rsp_if.worst_tolerance    = out_item.worst_tolerance;
   assign rsp_if.pass_count         = out_item.pass_count;
   assign rsp_if.pass_done          = out_item.pass_done;
   assign rsp_if.target_met         = out_item.target_met;

endmodule

### sv/mccm_queue.sv
// front end: input item queue between the request channel and the back end
module mccm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mccm_pkg::req_type push_item,
   output logic             pop_valid,
   input  logic             pop,
   output mccm_pkg::req_type pop_item
);
   import mccm_pkg::*;

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int FILL_W = $clog2(QDEPTH + 1);

   req_type             mem_ff [QDEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != FILL_W'(QDEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

### sv/mccm_div.sv
// restoring divider, one quotient bit per cycle
module mccm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mccm_pkg::DVD_W-1:0] dividend,
   input  logic [mccm_pkg::DVS_W-1:0] divisor,
   output logic                       done,
   output logic [mccm_pkg::DVD_W-1:0] quotient
);
   import mccm_pkg::*;

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DVS_W:0]   trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

### sv/mccm_back.sv
// back end: running totals, statistics sequencer and result register
module mccm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_pop,
   input  mccm_pkg::req_type    item,
   input  mccm_pkg::csr_wr_type csr_wr,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mccm_pkg::rsp_type    out_item
);
   import mccm_pkg::*;

   state_type              state_ff, state_in;
   logic [EL_W-1:0]        el_ff, el_in, cur_ff, cur_in;
   logic [PASS_BITS-1:0]   pass_ff, pass_in;
   logic [TOL_W-1:0]       worst_ff, worst_in, tol_ff, tol_in;
   logic                   reached_ff, reached_in, valid_ff, valid_in, last_ff, last_in;
   logic [EST_W-1:0]       e_ff, e_in, mean_ff, mean_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SQ_W-1:0]        v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [NZ_W+BR_W-1:0]   bail_ff, bail_in;
   logic [4:0]             rc_ff;
   logic [CF_W-1:0]        cf_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic [BR_W-1:0]        br_ff;
   logic                   ov_ff, ov_in;
   rsp_type                out_ff, out_in;

   logic [SUM_W-1:0]       sum_ff [MAX_RESULTS];
   logic [SUM_W-1:0]       sq_ff [MAX_RESULTS];
   logic [NZ_W-1:0]        nz_ff [MAX_RESULTS];
   logic                   st_clr, st_we, nz_we;
   logic [SUM_W-1:0]       sum_wd, sq_wd;
   logic [NZ_W-1:0]        nz_wd;

   logic                   div_start, div_done;
   logic [DVD_W-1:0]       div_dvd, div_q;
   logic [DVS_W-1:0]       div_dvs;

   logic [CNT_W-1:0]       cnt;
   logic [EL_W-1:0]        el_c;
   logic [SUM_W:0]         sum_t, sq_t;
   logic [PROD_W:0]        rnd;
   logic [EST_W-1:0]       msq, m_c;
   logic [SQ_W-1:0]        sq_try;
   logic [TOL_W-1:0]       t_c;

   mccm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_valid = ov_ff;
   assign out_item  = out_ff;

   always_comb begin
      state_in   = state_ff;
      el_in      = el_ff;
      cur_in     = cur_ff;
      pass_in    = pass_ff;
      worst_in   = worst_ff;
      tol_in     = tol_ff;
      reached_in = reached_ff;
      valid_in   = valid_ff;
      last_in    = last_ff;
      e_in       = e_ff;
      mean_in    = mean_ff;
      prod_in    = prod_ff;
      v_in       = v_ff;
      res_in     = res_ff;
      bit_in     = bit_ff;
      bail_in    = bail_ff;
      ov_in      = ov_ff && !out_ready;
      out_in     = out_ff;
      item_pop   = 1'b0;
      st_clr     = 1'b0;
      st_we      = 1'b0;
      nz_we      = 1'b0;
      sum_wd     = '0;
      sq_wd      = '0;
      nz_wd      = '0;
      div_start  = 1'b0;
      div_dvd    = '0;
      div_dvs    = '0;
      cnt        = (rc_ff == '0) ? CNT_W'(1) : CNT_W'(rc_ff);
      if (cnt > CNT_W'(MAX_RESULTS)) begin
         cnt = CNT_W'(MAX_RESULTS);
      end
      el_c   = (CNT_W'(cur_ff) >= cnt) ? '0 : cur_ff;
      rnd    = {1'b0, prod_ff} + (PROD_W + 1)'(24'h800000);
      sum_t  = {1'b0, sum_ff[el_ff]} + (SUM_W + 1)'(e_ff);
      sq_t   = {1'b0, sq_ff[el_ff]} + (SUM_W + 1)'(rnd[PROD_W:24]);
      msq    = prod_ff[PROD_W-2:24];
      m_c    = (div_q > DVD_W'(ONE_Q24)) ? ONE_Q24 : div_q[EST_W-1:0];
      sq_try = res_ff + bit_ff;
      t_c    = (div_q > DVD_W'(TOL_MAX)) ? TOL_MAX : div_q[TOL_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.action == ACT_CLEAR) begin
                  st_clr     = 1'b1;
                  pass_in    = '0;
                  cur_in     = '0;
                  worst_in   = '0;
                  reached_in = 1'b0;
                  el_in      = '0;
                  mean_in    = '0;
                  tol_in     = '0;
                  valid_in   = 1'b0;
                  last_in    = 1'b0;
                  state_in   = ST_EMIT;
               end else begin
                  el_in = el_c;
                  if (el_c == '0) begin
                     if (pass_ff != PASS_MAX) begin
                        pass_in = pass_ff + 1'b1;
                     end
                     worst_in = '0;
                  end
                  last_in  = (CNT_W'(el_c) == cnt - 1'b1);
                  cur_in   = (CNT_W'(el_c) == cnt - 1'b1) ? '0 : el_c + 1'b1;
                  e_in     = (item.estimate_value > ONE_Q24) ? ONE_Q24 : item.estimate_value;
                  tol_in   = '0;
                  valid_in = 1'b0;
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            prod_in  = e_ff * e_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            st_we     = 1'b1;
            sum_wd    = sum_t[SUM_W] ? SUM_MAX : sum_t[SUM_W-1:0];
            sq_wd     = sq_t[SUM_W] ? SUM_MAX : sq_t[SUM_W-1:0];
            div_start = 1'b1;
            div_dvd   = sum_wd;
            div_dvs   = DVS_W'(pass_ff);
            state_in  = ST_DMEAN;
         end
         ST_DMEAN: begin
            if (div_done) begin
               mean_in = m_c;
               if (m_c != '0) begin
                  if (e_ff != '0 && nz_ff[el_ff] != NZ_MAX) begin
                     nz_we = 1'b1;
                     nz_wd = nz_ff[el_ff] + 1'b1;
                  end
                  state_in = (pass_ff > PASS_BITS'(1)) ? ST_MSQ : ST_FIN;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MSQ: begin
            prod_in   = mean_ff * mean_ff;
            div_start = 1'b1;
            div_dvd   = sq_ff[el_ff];
            div_dvs   = DVS_W'(pass_ff);
            state_in  = ST_DEX2;
         end
         ST_DEX2: begin
            if (div_done) begin
               if (div_q > DVD_W'(msq)) begin
                  div_start = 1'b1;
                  div_dvd   = div_q - DVD_W'(msq);
                  div_dvs   = DVS_W'(pass_ff - 1'b1);
                  state_in  = ST_DVAR;
               end else begin
                  v_in     = '0;
                  res_in   = '0;
                  bit_in   = SQ_W'(1) << (SQ_W - 1);
                  state_in = ST_SQRT;
               end
            end
         end
         ST_DVAR: begin
            if (div_done) begin
               v_in     = {m_c, 24'd0};
               res_in   = '0;
               bit_in   = SQ_W'(1) << (SQ_W - 1);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (v_ff >= sq_try) begin
               v_in   = v_ff - sq_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_TMUL;
            end
         end
         ST_TMUL: begin
            prod_in  = PROD_W'(cf_ff) * PROD_W'(res_ff[EST_W-1:0]);
            bail_in  = (NZ_W + BR_W)'(nz_ff[el_ff]) * (NZ_W + BR_W)'(br_ff);
            state_in = ST_TSTART;
         end
         ST_TSTART: begin
            div_start = 1'b1;
            div_dvd   = {prod_ff[DVD_W-5:0], 4'd0};
            div_dvs   = DVS_W'(mean_ff);
            state_in  = ST_DTOL;
         end
         ST_DTOL: begin
            if (div_done) begin
               tol_in   = t_c;
               valid_in = 1'b1;
               if (t_c > worst_ff &&
                   (br_ff == '0 || (NZ_W + BR_W)'(pass_ff) < bail_ff)) begin
                  worst_in = t_c;
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (last_ff && pass_ff >= PASS_TARGET && worst_ff <= TOL_W'(acc_ff) &&
                worst_ff != '0) begin
               reached_in = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!ov_ff || out_ready) begin
               ov_in                     = 1'b1;
               out_in.element_index      = IDX_W'(el_ff);
               out_in.mean_value         = mean_ff;
               out_in.relative_tolerance = tol_ff;
               out_in.tolerance_valid    = valid_ff;
               out_in.worst_tolerance    = worst_ff;
               out_in.pass_count         = PCO_W'(pass_ff);
               out_in.pass_done          = last_ff;
               out_in.target_met         = reached_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cur_ff     <= '0;
         pass_ff    <= '0;
         worst_ff   <= '0;
         reached_ff <= 1'b0;
         ov_ff      <= 1'b0;
         rc_ff      <= 5'd1;
         cf_ff      <= CF_W'(8028);
         acc_ff     <= ACC_W'(6554);
         br_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         cur_ff     <= cur_in;
         pass_ff    <= pass_in;
         worst_ff   <= worst_in;
         reached_ff <= reached_in;
         ov_ff      <= ov_in;
         if (csr_wr.valid) begin
            unique case (csr_wr.index)
               REG_RESULT_COUNT: rc_ff  <= csr_wr.data[4:0];
               REG_CONFIDENCE:   cf_ff  <= csr_wr.data[CF_W-1:0];
               REG_ACCURACY:     acc_ff <= csr_wr.data[ACC_W-1:0];
               REG_BAILOUT:      br_ff  <= csr_wr.data[BR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      el_ff    <= el_in;
      tol_ff   <= tol_in;
      valid_ff <= valid_in;
      last_ff  <= last_in;
      e_ff     <= e_in;
      mean_ff  <= mean_in;
      prod_ff  <= prod_in;
      v_ff     <= v_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      bail_ff  <= bail_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset || st_clr) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            sum_ff[i] <= '0;
            sq_ff[i]  <= '0;
            nz_ff[i]  <= '0;
         end
      end else begin
         if (st_we) begin
            sum_ff[el_ff] <= sum_wd;
            sq_ff[el_ff]  <= sq_wd;
         end
         if (nz_we) begin
            nz_ff[el_ff] <= nz_wd;
         end
      end
   end

endmodule
